[src/rplc_pkg.sv]
// Package for the rectilinear polygon lattice point counter.
// Holds the widths, direction codes and stream layout. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rplc_pkg;

    // Coordinate and step widths
    localparam int COORD_BITS = 32;
    localparam int DIST_BITS  = 20;

    // Accumulator and result widths
    localparam int AREA_W  = 64;
    localparam int BOUND_W = 48;
    localparam int COUNT_W = 63;

    // Position update is worked at this width so that wrap can be seen
    localparam int MOVE_W = ((COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS) + 2;

    // Area term: magnitude times distance, widened to at least 65 bits for checks
    localparam int PROD_W = COORD_BITS + DIST_BITS;
    localparam int PEXT_W = (PROD_W > AREA_W) ? PROD_W : AREA_W + 1;

    // Stream field widths
    localparam int DIR_W       = 2;
    localparam int DIST_FIELD_W = 20;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 64;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

endpackage

`default_nettype wire

[src/rectilinear_polygon_lattice_count_top.sv]
// Rectilinear polygon lattice point counter: walks moves, accumulates shoelace area and perimeter.
// The count passes the stage 1, stage 2 and result registers after the final move is taken.
// Throughput: one move per cycle, set by the position update and area accumulate;
// a final move, and the moves behind it, wait only while an earlier count is still held at the output.
// Reset (aresetn low, synchronous): position, area, perimeter and flags cleared, pipe empty.
// Depends on rplc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rectilinear_polygon_lattice_count_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // move stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rplc_pkg::S_TDATA_W-1:0]  s_tdata,   // [1:0] direction, [21:2] distance
    input  wire logic                            s_tlast,   // final_move
    // count stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [rplc_pkg::M_TDATA_W-1:0]       m_tdata    // [62:0] point_count, [63] overflow
);

    localparam int C  = rplc_pkg::COORD_BITS;
    localparam int D  = rplc_pkg::DIST_BITS;
    localparam int A  = rplc_pkg::AREA_W;
    localparam int B  = rplc_pkg::BOUND_W;
    localparam int MW = rplc_pkg::MOVE_W;
    localparam int PW = rplc_pkg::PROD_W;
    localparam int EW = rplc_pkg::PEXT_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic signed [C-1:0] pos_x_reg, pos_x_next;
    logic signed [C-1:0] pos_y_reg, pos_y_next;
    logic [B-1:0]        bound_reg, bound_next;
    logic [A-1:0]        area_reg,  area_next;
    logic                ovf_seen_reg, ovf_seen_next;

    // stage 1: area term of one move
    logic                p1_valid_reg, p1_valid_next;
    logic                p1_last_reg;
    logic [A-1:0]        p1_prod_reg;
    logic                p1_neg_reg;
    logic                p1_ovf_reg;
    logic [B-1:0]        p1_bound_reg;

    // stage 2: closed polygon totals
    logic                p2_valid_reg, p2_valid_next;
    logic [A-1:0]        p2_area_reg;
    logic [B-1:0]        p2_bound_reg;
    logic                p2_ovf_reg;

    // result register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [rplc_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // ---------------------------------------------------------------
    // Flow control
    // ---------------------------------------------------------------
    logic accept, step1, step2, out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign step2    = p2_valid_reg && out_free;
    assign step1    = p1_valid_reg && (!p1_last_reg || !p2_valid_reg || step2);
    assign s_tready = !p1_valid_reg || step1;
    assign accept   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Stage 0: position update and area term
    // ---------------------------------------------------------------
    logic [rplc_pkg::DIR_W-1:0] dir;
    logic [D-1:0]               step_len;
    logic signed [C-1:0]        area_c;
    logic                       area_negate;
    logic signed [C-1:0]        move_c;
    logic                       move_up;
    logic                       move_on_x;
    logic [MW-1:0]              move_ext;
    logic [MW-1:0]              moved;
    logic                       coord_ovf;
    logic [C-1:0]               mag;
    logic [PW-1:0]              prod;
    logic [EW-1:0]              prod_ext;
    logic                       term_neg;
    logic                       prod_ovf;
    logic [B:0]                 bound_sum;

    assign dir      = s_tdata[1:0];
    assign step_len = D'(s_tdata[21:2]);

    // pick the coordinate for the cross product and the one that moves
    always_comb begin
        area_c      = pos_x_reg;
        area_negate = 1'b0;
        move_c      = pos_y_reg;
        move_up     = 1'b1;
        move_on_x   = 1'b0;
        unique case (dir)
            rplc_pkg::DIR_UP: begin
                area_c      = pos_x_reg;
                area_negate = 1'b0;
                move_c      = pos_y_reg;
                move_up     = 1'b1;
                move_on_x   = 1'b0;
            end
            rplc_pkg::DIR_DOWN: begin
                area_c      = pos_x_reg;
                area_negate = 1'b1;
                move_c      = pos_y_reg;
                move_up     = 1'b0;
                move_on_x   = 1'b0;
            end
            rplc_pkg::DIR_RIGHT: begin
                area_c      = pos_y_reg;
                area_negate = 1'b1;
                move_c      = pos_x_reg;
                move_up     = 1'b1;
                move_on_x   = 1'b1;
            end
            rplc_pkg::DIR_LEFT: begin
                area_c      = pos_y_reg;
                area_negate = 1'b0;
                move_c      = pos_x_reg;
                move_up     = 1'b0;
                move_on_x   = 1'b1;
            end
            default: begin
                area_c      = pos_x_reg;
                area_negate = 1'b0;
                move_c      = pos_y_reg;
                move_up     = 1'b1;
                move_on_x   = 1'b0;
            end
        endcase
    end

    // new coordinate; wraps when the top bits no longer agree
    assign move_ext  = MW'(move_c);
    assign moved     = move_up ? (move_ext + MW'(step_len)) : (move_ext - MW'(step_len));
    assign coord_ovf = !((&moved[MW-1:C-1]) || !(|moved[MW-1:C-1]));

    // magnitude times distance, sign kept apart
    assign mag      = area_c[C-1] ? C'(~area_c + C'(1)) : C'(area_c);
    assign prod     = PW'(mag) * PW'(step_len);
    assign prod_ext = EW'(prod);
    assign term_neg = area_c[C-1] ^ area_negate;
    assign prod_ovf = (|prod_ext[EW-1:A])
                   || (!term_neg && prod_ext[A-1])
                   || (term_neg && prod_ext[A-1] && (|prod_ext[A-2:0]));

    // perimeter
    assign bound_sum = (B+1)'(bound_reg) + (B+1)'(step_len);

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        bound_next = bound_reg;
        if (accept) begin
            if (s_tlast) begin
                pos_x_next = '0;
                pos_y_next = '0;
                bound_next = '0;
            end else begin
                bound_next = bound_sum[B-1:0];
                if (move_on_x) begin
                    pos_x_next = moved[C-1:0];
                end else begin
                    pos_y_next = moved[C-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: area accumulate
    // ---------------------------------------------------------------
    logic [A-1:0] area_sum;
    logic         term_msb;
    logic         add_ovf;
    logic         ovf_total;

    assign area_sum = area_reg + (p1_prod_reg ^ {A{p1_neg_reg}}) + A'(p1_neg_reg);
    assign term_msb = p1_neg_reg ? ((|p1_prod_reg)
                                    && (!p1_prod_reg[A-1] || !(|p1_prod_reg[A-2:0])))
                                 : p1_prod_reg[A-1];
    assign add_ovf   = (area_reg[A-1] == term_msb) && (area_sum[A-1] != area_reg[A-1]);
    assign ovf_total = ovf_seen_reg || p1_ovf_reg || add_ovf;

    always_comb begin
        area_next     = area_reg;
        ovf_seen_next = ovf_seen_reg;
        if (step1) begin
            if (p1_last_reg) begin
                area_next     = '0;
                ovf_seen_next = 1'b0;
            end else begin
                area_next     = area_sum;
                ovf_seen_next = ovf_total;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: |area|/2 + perimeter/2 + 1
    // ---------------------------------------------------------------
    logic [A-1:0]                 area_mag;
    logic [rplc_pkg::COUNT_W-1:0] count;

    assign area_mag = p2_area_reg[A-1] ? (~p2_area_reg + A'(1)) : p2_area_reg;
    assign count    = rplc_pkg::COUNT_W'(area_mag >> 1)
                    + rplc_pkg::COUNT_W'(p2_bound_reg >> 1)
                    + rplc_pkg::COUNT_W'(1);

    // ---------------------------------------------------------------
    // Valid bits
    // ---------------------------------------------------------------
    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (step1) begin
            p1_valid_next = 1'b0;
        end

        p2_valid_next = p2_valid_reg;
        if (step1 && p1_last_reg) begin
            p2_valid_next = 1'b1;
        end else if (step2) begin
            p2_valid_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (step2) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            bound_reg    <= '0;
            area_reg     <= '0;
            ovf_seen_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            bound_reg    <= bound_next;
            area_reg     <= area_next;
            ovf_seen_reg <= ovf_seen_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_last_reg  <= s_tlast;
            p1_prod_reg  <= prod_ext[A-1:0];
            p1_neg_reg   <= term_neg;
            p1_ovf_reg   <= coord_ovf || prod_ovf || bound_sum[B];
            p1_bound_reg <= bound_sum[B-1:0];
        end
        if (step1 && p1_last_reg) begin
            p2_area_reg  <= area_sum;
            p2_bound_reg <= p1_bound_reg;
            p2_ovf_reg   <= ovf_total;
        end
        if (step2) begin
            m_tdata_reg  <= {p2_ovf_reg, count};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
